// ===== hw/rtl/capped_tube_triangle_indexer_defines.svh =====
// assertion macros used by the triangle indexer top level
`ifndef CAPPED_TUBE_TRIANGLE_INDEXER_DEFINES_SVH
`define CAPPED_TUBE_TRIANGLE_INDEXER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CTTI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctti same-cycle check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define CTTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctti next-cycle check failed");

`endif

// ===== hw/rtl/ctti_pkg.sv =====
// shared widths, register codes and structs of the triangle indexer
package ctti_pkg;

  localparam int TRI_W     = 17;
  localparam int IDX_W     = 16;
  localparam int OWN_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_RINGS    = 256;
  localparam int DEF_MAX_SEGMENTS = 256;

  localparam logic [CFG_W-1:0] RING_COUNT_RST = CFG_W'(2);
  localparam logic [CFG_W-1:0] VERTICES_RST   = CFG_W'(3);

  // register indexes of the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_COUNT = 2'd0,
    CFG_VERTICES   = 2'd1,
    CFG_WINDING    = 2'd2
  } ctti_cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] ring_count;
    logic [CFG_W-1:0] vertices_per_ring;
    logic             inward_winding;
  } ctti_cfg_t;

  // per-item classification carried down the pipe
  typedef struct packed {
    logic side;
    logic cap;
    logic par;
    logic inner;
  } ctti_flags_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic [OWN_W-1:0] owner_ring;
    logic             is_cap;
    logic             valid_res;
  } ctti_res_t;

endpackage

// ===== hw/rtl/ctti_if.sv =====
// valid/ready channel interfaces: triangle items, results, config writes
interface ctti_item_if import ctti_pkg::*;;
  logic             valid;
  logic             ready;
  logic [TRI_W-1:0] triangle_number;

  modport source (output valid, output triangle_number, input ready);
  modport sink   (input valid, input triangle_number, output ready);
endinterface

interface ctti_res_if import ctti_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index_a;
  logic [IDX_W-1:0] index_b;
  logic [IDX_W-1:0] index_c;
  logic [OWN_W-1:0] owner_ring;
  logic             is_cap;
  logic             valid_res;

  modport source (output valid, output index_a, output index_b, output index_c,
                  output owner_ring, output is_cap, output valid_res, input ready);
  modport sink   (input valid, input index_a, input index_b, input index_c,
                  input owner_ring, input is_cap, input valid_res, output ready);
endinterface

interface ctti_cfg_if import ctti_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/capped_tube_triangle_indexer.sv =====
// Capped tube triangle indexer, top level.
// item_i carries a triangle number; res_o returns the three vertex indices,
// owner ring, cap flag and a validity flag of that triangle. cfg_i writes
// ring_count (index 0), vertices_per_ring (index 1) and inward_winding
// (index 2); it is always ready and other indexes are dropped. Configure
// only while no item is in flight.
// Throughput: one triangle per cycle, sustained as long as res_o is ready.
// An accepted item passes through the input, classify, divide, ring base
// and output registers. The ring divide has a quotient width of 8 at the
// default ring limit. The ring/segment split of the side quads is a restoring divide
// resolving two quotient bits per stage; that chain sets the pipe depth.
// Every stage holds a valid bit and fills its bubble even while the output
// register waits, so new items are taken until the whole pipe is full.
// When the receiver stalls, results hold in the output register and
// nothing is lost or repeated.
// Reset empties the pipe and loads ring_count 2, vertices_per_ring 3 and
// exterior winding.
`include "capped_tube_triangle_indexer_defines.svh"

module capped_tube_triangle_indexer import ctti_pkg::*; #(
  parameter int MAX_RINGS    = DEF_MAX_RINGS,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctti_item_if.sink  item_i,
  ctti_res_if.source res_o,
  ctti_cfg_if.sink   cfg_i
);

  localparam int CFG_MAX  = (2 ** CFG_W) - 1;
  localparam int RING_LIM = (MAX_RINGS < CFG_MAX) ? MAX_RINGS : CFG_MAX;
  localparam int SEG_LIM  = (MAX_SEGMENTS < CFG_MAX) ? MAX_SEGMENTS : CFG_MAX;
  localparam int RW       = $clog2(RING_LIM + 1);
  localparam int VW       = $clog2(SEG_LIM + 1);
  localparam int PVW      = RW + VW;
  localparam int KW       = VW + 1;
  localparam int QW       = $clog2(RING_LIM);
  localparam int DS       = (QW + 1) / 2;
  localparam int QWE      = 2 * DS;
  localparam int PRW      = TRI_W - 1;
  localparam int CW       = (PRW > VW + QWE) ? PRW : VW + QWE;
  localparam int EW       = (PVW + 1 > TRI_W) ? PVW + 1 : TRI_W;
  localparam int NS       = DS + 4;

  ctti_cfg_t cfg;

  ctti_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // pipe control: valid bit per stage, stage loads when empty or moving on
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_in;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || res_o.ready;
    for (int n = NS - 2; n >= 0; n--) begin
      en[n] = !vld_q[n] || en[n+1];
    end
  end

  assign vld_in       = {vld_q[NS-2:0], item_i.valid};
  assign item_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int n = 0; n < NS; n++) begin
        if (en[n]) vld_q[n] <= vld_in[n];
      end
    end
  end

  // input stage: saturate config and form ring-pair vertex count
  logic [RW-1:0]  rs_in;
  logic [VW-1:0]  vs_in;
  logic           ok_in;
  logic [PVW-1:0] pv_in;

  always_comb begin
    ok_in = (cfg.ring_count >= CFG_W'(2)) && (cfg.vertices_per_ring >= CFG_W'(3));
    rs_in = (cfg.ring_count > CFG_W'(RING_LIM)) ? RW'(RING_LIM) : RW'(cfg.ring_count);
    vs_in = (cfg.vertices_per_ring > CFG_W'(SEG_LIM)) ? VW'(SEG_LIM)
                                                       : VW'(cfg.vertices_per_ring);
    pv_in = PVW'(rs_in - RW'(1)) * PVW'(vs_in);
  end

  logic [TRI_W-1:0] s1_t_q;
  logic [PVW-1:0]   s1_pv_q;
  logic [VW-1:0]    s1_vs_q;
  logic [RW-1:0]    s1_rs_q;
  logic             s1_inner_q;
  logic             s1_ok_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_t_q     <= item_i.triangle_number;
      s1_pv_q    <= pv_in;
      s1_vs_q    <= vs_in;
      s1_rs_q    <= rs_in;
      s1_inner_q <= cfg.inward_winding;
      s1_ok_q    <= ok_in;
    end
  end

  // classify: side range, cap range or past the end
  logic [EW-1:0] sides;
  logic [EW-1:0] t_ext;
  logic [EW-1:0] k_full;
  logic [KW-1:0] caps;
  ctti_flags_t   flags_d;

  always_comb begin
    sides   = EW'({s1_pv_q, 1'b0});
    t_ext   = EW'(s1_t_q);
    k_full  = t_ext - sides;
    caps    = {s1_vs_q - VW'(2), 1'b0};
    flags_d.side  = s1_ok_q && (t_ext < sides);
    flags_d.cap   = s1_ok_q && !flags_d.side && (k_full < EW'(caps));
    flags_d.par   = s1_t_q[0];
    flags_d.inner = s1_inner_q;
  end

  // divide stages: entry 0 is the classify register
  ctti_flags_t    p_flags_q [DS+1];
  logic [KW-1:0]  p_k_q     [DS+1];
  logic [PVW-1:0] p_pv_q    [DS+1];
  logic [VW-1:0]  p_vs_q    [DS+1];
  logic [RW-1:0]  p_rs_q    [DS+1];
  logic [CW-1:0]  p_rem_q   [DS+1];
  logic [QWE-1:0] p_quot_q  [DS+1];
  logic [CW-1:0]  rem_nx    [DS];
  logic [QWE-1:0] quot_nx   [DS];

  for (genvar j = 0; j < DS; j++) begin : g_div
    ctti_div_stage #(
      .CW     (CW),
      .VW     (VW),
      .QWE    (QWE),
      .BIT_HI (QWE - 1 - 2 * j)
    ) u_div (
      .rem_i  (p_rem_q[j]),
      .div_i  (p_vs_q[j]),
      .quot_i (p_quot_q[j]),
      .rem_o  (rem_nx[j]),
      .quot_o (quot_nx[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_flags_q[0] <= flags_d;
      p_k_q[0]     <= k_full[KW-1:0];
      p_pv_q[0]    <= s1_pv_q;
      p_vs_q[0]    <= s1_vs_q;
      p_rs_q[0]    <= s1_rs_q;
      p_rem_q[0]   <= CW'(s1_t_q[TRI_W-1:1]);
      p_quot_q[0]  <= '0;
    end
    for (int j = 0; j < DS; j++) begin
      if (en[j+2]) begin
        p_flags_q[j+1] <= p_flags_q[j];
        p_k_q[j+1]     <= p_k_q[j];
        p_pv_q[j+1]    <= p_pv_q[j];
        p_vs_q[j+1]    <= p_vs_q[j];
        p_rs_q[j+1]    <= p_rs_q[j];
        p_rem_q[j+1]   <= rem_nx[j];
        p_quot_q[j+1]  <= quot_nx[j];
      end
    end
  end

  // ring base product
  logic [QW-1:0]    ring_d;
  ctti_flags_t      s3_flags_q;
  logic [KW-1:0]    s3_k_q;
  logic [PVW-1:0]   s3_pv_q;
  logic [VW-1:0]    s3_vs_q;
  logic [RW-1:0]    s3_rs_q;
  logic [QW-1:0]    s3_ring_q;
  logic [VW-1:0]    s3_seg_q;
  logic [QW+VW-1:0] s3_ringv_q;

  assign ring_d = p_quot_q[DS][QW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[NS-2]) begin
      s3_flags_q <= p_flags_q[DS];
      s3_k_q     <= p_k_q[DS];
      s3_pv_q    <= p_pv_q[DS];
      s3_vs_q    <= p_vs_q[DS];
      s3_rs_q    <= p_rs_q[DS];
      s3_ring_q  <= ring_d;
      s3_seg_q   <= p_rem_q[DS][VW-1:0];
      s3_ringv_q <= (QW+VW)'(ring_d) * (QW+VW)'(p_vs_q[DS]);
    end
  end

  // index assembly into the output register
  ctti_res_t res_d;
  ctti_res_t out_q;

  ctti_index_calc #(
    .VW  (VW),
    .RW  (RW),
    .QW  (QW),
    .KW  (KW),
    .PVW (PVW)
  ) u_calc (
    .flags_i (s3_flags_q),
    .k_i     (s3_k_q),
    .pv_i    (s3_pv_q),
    .vs_i    (s3_vs_q),
    .rs_i    (s3_rs_q),
    .ring_i  (s3_ring_q),
    .seg_i   (s3_seg_q),
    .ringv_i (s3_ringv_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) out_q <= res_d;
  end

  assign res_o.valid      = vld_q[NS-1];
  assign res_o.index_a    = out_q.index_a;
  assign res_o.index_b    = out_q.index_b;
  assign res_o.index_c    = out_q.index_c;
  assign res_o.owner_ring = out_q.owner_ring;
  assign res_o.is_cap     = out_q.is_cap;
  assign res_o.valid_res  = out_q.valid_res;

  // checks
  `CTTI_ASSERT_NOW(a_invalid_zero, res_o.valid && !res_o.valid_res, (res_o.index_a == '0) && (res_o.index_b == '0) && (res_o.index_c == '0) && (res_o.owner_ring == '0) && !res_o.is_cap)
  `CTTI_ASSERT_NOW(a_cap_valid, res_o.valid && res_o.is_cap, res_o.valid_res)
  `CTTI_ASSERT_NOW(a_full_only, !item_i.ready, res_o.valid && !res_o.ready && (&vld_q))
  `CTTI_ASSERT_NEXT(a_enter, item_i.valid && item_i.ready, vld_q[0])

endmodule

// ===== hw/rtl/ctti_cfg_regs.sv =====
// configuration register file of the triangle indexer
module ctti_cfg_regs import ctti_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctti_cfg_if.sink  cfg_i,
  output ctti_cfg_t cfg_o
);

  ctti_cfg_t cfg_q;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register write, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_count        <= RING_COUNT_RST;
      cfg_q.vertices_per_ring <= VERTICES_RST;
      cfg_q.inward_winding    <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RING_COUNT: cfg_q.ring_count        <= cfg_i.data;
        CFG_VERTICES:   cfg_q.vertices_per_ring <= cfg_i.data;
        CFG_WINDING:    cfg_q.inward_winding    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ctti_div_stage.sv =====
// two quotient bits of a restoring divide, combinational
module ctti_div_stage #(
  parameter int CW     = 17,
  parameter int VW     = 9,
  parameter int QWE    = 8,
  parameter int BIT_HI = 7
) (
  input  logic [CW-1:0]  rem_i,
  input  logic [VW-1:0]  div_i,
  input  logic [QWE-1:0] quot_i,
  output logic [CW-1:0]  rem_o,
  output logic [QWE-1:0] quot_o
);

  logic [CW-1:0] d_hi;
  logic [CW-1:0] d_lo;
  logic [CW-1:0] rem_mid;
  logic          ge_hi;
  logic          ge_lo;

  // compare and subtract, higher bit then lower bit
  always_comb begin
    d_hi    = CW'(div_i) << BIT_HI;
    d_lo    = CW'(div_i) << (BIT_HI - 1);
    ge_hi   = rem_i >= d_hi;
    rem_mid = ge_hi ? rem_i - d_hi : rem_i;
    ge_lo   = rem_mid >= d_lo;
    rem_o   = ge_lo ? rem_mid - d_lo : rem_mid;
    quot_o  = quot_i;
    quot_o[BIT_HI]     = ge_hi;
    quot_o[BIT_HI - 1] = ge_lo;
  end

endmodule

// ===== hw/rtl/ctti_index_calc.sv =====
// vertex indices and owner ring from ring, segment and cap position
module ctti_index_calc import ctti_pkg::*; #(
  parameter int VW  = 9,
  parameter int RW  = 9,
  parameter int QW  = 8,
  parameter int KW  = 10,
  parameter int PVW = 18
) (
  input  ctti_flags_t       flags_i,
  input  logic [KW-1:0]     k_i,
  input  logic [PVW-1:0]    pv_i,
  input  logic [VW-1:0]     vs_i,
  input  logic [RW-1:0]     rs_i,
  input  logic [QW-1:0]     ring_i,
  input  logic [VW-1:0]     seg_i,
  input  logic [QW+VW-1:0]  ringv_i,
  output ctti_res_t         res_o
);

  localparam int AW = PVW + 1;

  logic [VW:0]   seg_inc;
  logic [VW-1:0] seg_nx;
  logic [AW-1:0] a, b, c, d;
  logic [AW-1:0] s, base;

  always_comb begin
    // segment wraps back to zero at the ring size
    seg_inc = {1'b0, seg_i} + (VW+1)'(1);
    seg_nx  = (seg_inc == {1'b0, vs_i}) ? '0 : seg_inc[VW-1:0];
    a = AW'(ringv_i) + AW'(seg_i);
    b = AW'(ringv_i) + AW'(seg_nx);
    c = a + AW'(vs_i);
    d = b + AW'(vs_i);
    // fan position and back ring base
    s    = AW'(k_i >> 1) + AW'(1);
    base = AW'(pv_i);

    res_o = '0;
    if (flags_i.side) begin
      res_o.valid_res  = 1'b1;
      res_o.owner_ring = OWN_W'(ring_i);
      if (!flags_i.par) begin
        res_o.index_a = IDX_W'(a);
        res_o.index_b = flags_i.inner ? IDX_W'(b) : IDX_W'(c);
        res_o.index_c = flags_i.inner ? IDX_W'(c) : IDX_W'(b);
      end else begin
        res_o.index_a = IDX_W'(b);
        res_o.index_b = flags_i.inner ? IDX_W'(d) : IDX_W'(c);
        res_o.index_c = flags_i.inner ? IDX_W'(c) : IDX_W'(d);
      end
    end else if (flags_i.cap) begin
      res_o.valid_res = 1'b1;
      res_o.is_cap    = 1'b1;
      if (!k_i[0]) begin
        // front fan, owned by ring zero
        res_o.index_a = '0;
        res_o.index_b = flags_i.inner ? IDX_W'(s + AW'(1)) : IDX_W'(s);
        res_o.index_c = flags_i.inner ? IDX_W'(s) : IDX_W'(s + AW'(1));
      end else begin
        // back fan, owned by the last ring
        res_o.owner_ring = OWN_W'(rs_i - RW'(1));
        res_o.index_a    = IDX_W'(base);
        res_o.index_b    = flags_i.inner ? IDX_W'(base + s) : IDX_W'(base + s + AW'(1));
        res_o.index_c    = flags_i.inner ? IDX_W'(base + s + AW'(1)) : IDX_W'(base + s);
      end
    end
  end

endmodule
